[design/i2a_fmt_pkg.sv]
// ----------------------------------------------------------------------------
// i2a_fmt_pkg
// Shared types and constants of the integer-to-ASCII field formatter.
// ----------------------------------------------------------------------------
package i2a_fmt_pkg;

    // field width limit and fixed payload widths
    localparam int MAX_FIELD_WIDTH = 64;
    localparam int VALUE_W         = 64;
    localparam int FWIDTH_W        = 7;
    localparam int CHAR_W          = 7;

    // digit store: twenty 4-bit digits, most significant at the top
    localparam int NDIG_MAX        = 20;
    localparam int DIG_W           = 4 * NDIG_MAX;
    localparam int NDIG_W          = 5;
    localparam int BITCNT_W        = 6;

    // conversion codes
    typedef enum logic [1:0] {
        OP_SDEC    = 2'd0,
        OP_UDEC    = 2'd1,
        OP_HEX     = 2'd2,
        OP_HEX_ALT = 2'd3
    } opcode_t;

    // ascii codes
    localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CH_A     = 7'h61;
    localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 7'h20;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_NORM,
        ST_EMIT
    } state_t;

    // one digit value to its ascii character
    function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
        logic [CHAR_W-1:0] c;
        if (d >= 4'd10) begin
            c = CH_A + CHAR_W'(d - 4'd10);
        end else begin
            c = CH_ZERO + CHAR_W'(d);
        end
        return c;
    endfunction

endpackage

[design/integer_to_ascii_field_formatter.sv]
// ----------------------------------------------------------------------------
// integer_to_ascii_field_formatter
// Formats one integer as signed decimal, unsigned decimal or lowercase hex,
// padded to a minimum field width, and sends it out one character per beat.
// ----------------------------------------------------------------------------
// One request is taken when the block is idle. A decimal request runs a
// shift-add-3 binary-to-decimal loop, one value bit per cycle; a hex request
// skips that loop. Up to 19 leading zero digits are then stripped, one digit
// per cycle. The characters follow at one per cycle while the output is taken,
// and the field is max(width, digits + sign) characters long.
// The next request is taken once the last character has been loaded into the
// output register.
// ----------------------------------------------------------------------------
module integer_to_ascii_field_formatter
    import i2a_fmt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          opcode,
    input  logic                wide,
    input  logic [VALUE_W-1:0]  value,
    input  logic                zero_pad,
    input  logic [FWIDTH_W-1:0] field_width,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [CHAR_W-1:0]   out_char,
    output logic                last_char
);

    state_t               state_reg, state_next;
    logic [VALUE_W-1:0]   mag_reg, mag_next;
    logic [DIG_W-1:0]     dig_reg, dig_next;
    logic [BITCNT_W-1:0]  cnt_reg, cnt_next;
    logic [NDIG_W-1:0]    ndig_reg, ndig_next;
    logic                 minus_reg, minus_next;
    logic                 zpad_reg, zpad_next;
    logic [FWIDTH_W-1:0]  width_reg, width_next;
    logic [FWIDTH_W-1:0]  len_reg, len_next;
    logic [FWIDTH_W-1:0]  pre_reg, pre_next;
    logic [FWIDTH_W-1:0]  pos_reg, pos_next;
    logic                 out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]    out_char_reg, out_char_next;
    logic                 last_reg, last_next;

    logic                 accept;
    logic                 is_hex;
    logic                 is_signed;
    logic                 neg_in;
    logic [VALUE_W-1:0]   mag_in;
    logic [31:0]          low_word;
    logic                 conv_done;
    logic                 norm_done;
    logic [FWIDTH_W-1:0]  need;
    logic [FWIDTH_W-1:0]  len_calc;
    logic                 emit_load;
    logic                 is_last;
    logic [3:0]           top_digit;
    logic [DIG_W-1:0]     dig_adj;

    assign accept    = in_valid && in_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign top_digit = dig_reg[DIG_W-1 -: 4];

    // request decode and magnitude
    always_comb
    begin
        is_hex    = (opcode == OP_HEX) || (opcode == OP_HEX_ALT);
        is_signed = (opcode == OP_SDEC);
        low_word  = value[31:0];
        if (wide) begin
            neg_in = is_signed && value[VALUE_W-1];
            mag_in = neg_in ? (VALUE_W'(0) - value) : value;
        end else begin
            neg_in = is_signed && low_word[31];
            mag_in = {32'd0, (neg_in ? (32'd0 - low_word) : low_word)};
        end
    end

    // add-3 correction of every decimal digit before the shift
    always_comb
    begin
        for (int i = 0; i < NDIG_MAX; i++) begin
            if (dig_reg[4*i +: 4] >= 4'd5) begin
                dig_adj[4*i +: 4] = dig_reg[4*i +: 4] + 4'd3;
            end else begin
                dig_adj[4*i +: 4] = dig_reg[4*i +: 4];
            end
        end
    end

    // sequencer conditions
    assign conv_done = (cnt_reg == BITCNT_W'(VALUE_W - 1));
    assign norm_done = (ndig_reg == NDIG_W'(1)) || (top_digit != 4'd0);
    assign emit_load = (state_reg == ST_EMIT) && (!out_valid_reg || out_ready);
    assign is_last   = (pos_reg == (len_reg - FWIDTH_W'(1)));

    // field length: width, but at least digits plus sign
    assign need     = FWIDTH_W'(ndig_reg) + FWIDTH_W'(minus_reg);
    assign len_calc = (width_reg > need) ? width_reg : need;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept) begin
                    state_next = is_hex ? ST_NORM : ST_CONV;
                end
            end
            ST_CONV:
            begin
                if (conv_done) begin
                    state_next = ST_NORM;
                end
            end
            ST_NORM:
            begin
                if (norm_done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (emit_load && is_last) begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and output register
    always_comb
    begin
        mag_next       = mag_reg;
        dig_next       = dig_reg;
        cnt_next       = cnt_reg;
        ndig_next      = ndig_reg;
        minus_next     = minus_reg;
        zpad_next      = zpad_reg;
        width_next     = width_reg;
        len_next       = len_reg;
        pre_next       = pre_reg;
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        last_next      = last_reg;

        // output beat drains
        if (out_valid_reg && out_ready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept) begin
                    mag_next   = mag_in;
                    dig_next   = is_hex ? {16'd0, mag_in} : '0;
                    cnt_next   = '0;
                    ndig_next  = NDIG_W'(NDIG_MAX);
                    minus_next = neg_in;
                    zpad_next  = zero_pad;
                    width_next = (field_width > FWIDTH_W'(MAX_FIELD_WIDTH))
                               ? FWIDTH_W'(MAX_FIELD_WIDTH) : field_width;
                end
            end
            ST_CONV:
            begin
                // shift one value bit into the decimal digits
                dig_next = {dig_adj[DIG_W-2:0], mag_reg[VALUE_W-1]};
                mag_next = {mag_reg[VALUE_W-2:0], 1'b0};
                cnt_next = cnt_reg + BITCNT_W'(1);
            end
            ST_NORM:
            begin
                if (norm_done) begin
                    len_next = len_calc;
                    pre_next = len_calc - FWIDTH_W'(ndig_reg);
                    pos_next = '0;
                end else begin
                    // drop one leading zero digit
                    dig_next  = {dig_reg[DIG_W-5:0], 4'd0};
                    ndig_next = ndig_reg - NDIG_W'(1);
                end
            end
            ST_EMIT:
            begin
                if (emit_load) begin
                    out_valid_next = 1'b1;
                    last_next      = is_last;
                    pos_next       = pos_reg + FWIDTH_W'(1);
                    if (pos_reg >= pre_reg) begin
                        out_char_next = digit_char(top_digit);
                        dig_next      = {dig_reg[DIG_W-5:0], 4'd0};
                    end else if (zpad_reg) begin
                        out_char_next = (minus_reg && (pos_reg == '0)) ? CH_MINUS : CH_ZERO;
                    end else begin
                        out_char_next = (minus_reg && (pos_reg == (pre_reg - FWIDTH_W'(1))))
                                      ? CH_MINUS : CH_SPACE;
                    end
                end
            end
            default:
            begin
                out_valid_next = out_valid_reg;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        mag_reg      <= mag_next;
        dig_reg      <= dig_next;
        cnt_reg      <= cnt_next;
        ndig_reg     <= ndig_next;
        minus_reg    <= minus_next;
        zpad_reg     <= zpad_next;
        width_reg    <= width_next;
        len_reg      <= len_next;
        pre_reg      <= pre_next;
        pos_reg      <= pos_next;
        out_char_reg <= out_char_next;
        last_reg     <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign last_char = last_reg;

    // digit count stays in range while stripping zeros
    a_ndig_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_NORM) |-> (ndig_reg >= NDIG_W'(1)) && (ndig_reg <= NDIG_W'(NDIG_MAX)))
        else $error("digit count out of range");

    // emit position never passes the field length
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (pos_reg < len_reg)
            && (len_reg <= FWIDTH_W'(MAX_FIELD_WIDTH)))
        else $error("emit position beyond field");

    // loading the final character returns the sequencer to idle
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_load && is_last) |=> (state_reg == ST_IDLE) && out_valid_reg && last_reg)
        else $error("final character did not end the field");

    // the sequencer stays in emit until a character is loaded, so no new request is taken mid-field
    a_accept_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) && !emit_load |=> (state_reg == ST_EMIT))
        else $error("field left before its last character");

endmodule
